FILE: sv/stc_pkg.sv
package stc_pkg;

   // Tree and table geometry
   localparam int LEAVES     = 1024;
   localparam int NODES      = 1024;
   localparam int TREE_DEPTH = 2 * LEAVES;
   localparam int TREE_AW    = $clog2(TREE_DEPTH);
   localparam int NODE_AW    = $clog2(NODES);

   // Field widths
   localparam int OP_W   = 2;
   localparam int NODE_W = 10;
   localparam int POS_W  = 10;
   localparam int CNT_W  = 11;

   // Stream word widths, padded to whole bytes
   localparam int REQ_FIELDS_W = OP_W + NODE_W + 2 * POS_W;
   localparam int REQ_W        = ((REQ_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_W        = ((CNT_W + 7) / 8) * 8;

   // Field offsets inside req_tdata
   localparam int NODE_LSB  = OP_W;
   localparam int FIRST_LSB = NODE_LSB + NODE_W;
   localparam int LAST_LSB  = FIRST_LSB + POS_W;

   typedef enum logic [OP_W-1:0] {
      OP_LOAD   = 2'd0,
      OP_TOGGLE = 2'd1,
      OP_QUERY  = 2'd2
   } op_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_FETCH,
      ST_TRD,
      ST_TWR,
      ST_QL,
      ST_QR,
      ST_QS,
      ST_DONE
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic ready;
      logic accept;
      logic clr_en;
      logic tog_init;
      logic tog_read;
      logic tog_write;
      logic q_init;
      logic q_left;
      logic q_right;
      logic q_shift;
      logic out_load;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      op_type req_op;
      op_type op;
      logic   node_ok;
      logic   clr_last;
      logic   i_top;
      logic   l_lt_r;
      logic   out_free;
   } sts_type;

endpackage

FILE: sv/stc_ctrl.sv
module stc_ctrl import stc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_tvalid,
   input  sts_type sts,
   output cmd_type cmd
);

   state_type state_ff, state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clr_en = 1'b1;
            if (sts.clr_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            cmd.ready  = 1'b1;
            cmd.accept = req_tvalid;
            if (req_tvalid && (sts.req_op == OP_TOGGLE || sts.req_op == OP_QUERY)) begin
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: begin
            case (sts.op)
               OP_TOGGLE: begin
                  if (sts.node_ok) begin
                     cmd.tog_init = 1'b1;
                     state_in     = ST_TRD;
                  end else begin
                     state_in = ST_IDLE;
                  end
               end
               OP_QUERY: begin
                  if (sts.node_ok) begin
                     cmd.q_init = 1'b1;
                     state_in   = ST_QL;
                  end else begin
                     state_in = ST_DONE;
                  end
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end
         ST_TRD: begin
            cmd.tog_read = 1'b1;
            state_in     = ST_TWR;
         end
         ST_TWR: begin
            cmd.tog_write = 1'b1;
            state_in      = sts.i_top ? ST_IDLE : ST_TRD;
         end
         ST_QL: begin
            if (sts.l_lt_r) begin
               cmd.q_left = 1'b1;
               state_in   = ST_QR;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_QR: begin
            cmd.q_right = 1'b1;
            state_in    = ST_QS;
         end
         ST_QS: begin
            cmd.q_shift = 1'b1;
            state_in    = ST_QL;
         end
         ST_DONE: begin
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

endmodule

FILE: sv/stc_dpath.sv
module stc_dpath import stc_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic [REQ_W-1:0] req_tdata,
   input  logic             rsp_tready,
   output logic             rsp_tvalid,
   output logic [RSP_W-1:0] rsp_tdata,
   input  cmd_type          cmd,
   output sts_type          sts
);

   // Interval table {last, first} and removed-count tree
   logic [2*POS_W-1:0] iv_mem [NODES];
   logic [CNT_W-1:0]   tree_mem [TREE_DEPTH];

   // Request fields
   op_type            req_op;
   logic [NODE_W-1:0] req_node;
   logic [POS_W-1:0]  req_first;
   logic [POS_W-1:0]  req_last;
   logic [POS_W-1:0]  first_clamp;
   logic [POS_W-1:0]  last_clamp;
   logic              req_node_ok;

   // Registers
   logic [TREE_AW-1:0] clr_ff, clr_in;
   logic [TREE_AW-1:0] i_ff, i_in;
   logic               lvl0_ff, lvl0_in;
   logic               up_ff, up_in;
   logic [TREE_AW:0]   l_ff, l_in;
   logic [TREE_AW:0]   r_ff, r_in;
   logic [CNT_W-1:0]   sum_ff, sum_in;
   logic               pend_ff, pend_in;
   op_type             op_ff, op_in;
   logic               node_ok_ff, node_ok_in;
   logic               out_valid_ff, out_valid_in;
   logic [CNT_W-1:0]   out_cnt_ff, out_cnt_in;
   logic [2*POS_W-1:0] iv_rd_ff;
   logic [CNT_W-1:0]   tree_rd_ff;

   // Tree port controls
   logic               tw_en;
   logic [TREE_AW-1:0] tw_addr;
   logic [CNT_W-1:0]   tw_data;
   logic               tr_en;
   logic [TREE_AW-1:0] tr_addr;
   logic               up_now;
   logic [TREE_AW:0]   r_dec;
   logic [POS_W-1:0]   iv_lo;
   logic [POS_W-1:0]   iv_hi;
   logic [CNT_W-1:0]   span;
   logic [CNT_W-1:0]   count;

   assign req_op    = op_type'(req_tdata[OP_W-1:0]);
   assign req_node  = req_tdata[NODE_LSB +: NODE_W];
   assign req_first = req_tdata[FIRST_LSB +: POS_W];
   assign req_last  = req_tdata[LAST_LSB +: POS_W];

   assign req_node_ok = 32'(req_node) < 32'(NODES);
   assign first_clamp = (32'(req_first) >= 32'(LEAVES)) ? POS_W'(LEAVES - 1) : req_first;
   assign last_clamp  = (32'(req_last) >= 32'(LEAVES)) ? POS_W'(LEAVES - 1) : req_last;

   assign iv_lo = iv_rd_ff[POS_W-1:0];
   assign iv_hi = iv_rd_ff[2*POS_W-1:POS_W];
   assign r_dec = r_ff - 1'b1;

   // Leaf decides direction; ancestors follow it
   assign up_now = lvl0_ff ? (tree_rd_ff == '0) : up_ff;

   // Tree write port: clearing sweep or toggle update
   assign tw_en   = cmd.clr_en | cmd.tog_write;
   assign tw_addr = cmd.clr_en ? clr_ff : i_ff;
   assign tw_data = cmd.clr_en ? '0 : (up_now ? tree_rd_ff + 1'b1 : tree_rd_ff - 1'b1);

   // Tree read port: toggle walk or query bounds
   assign tr_en = cmd.tog_read | (cmd.q_left & l_ff[0]) | (cmd.q_right & r_ff[0]);
   always_comb begin
      if (cmd.tog_read) begin
         tr_addr = i_ff;
      end else if (cmd.q_left) begin
         tr_addr = l_ff[TREE_AW-1:0];
      end else begin
         tr_addr = r_dec[TREE_AW-1:0];
      end
   end

   // Present count = interval width minus removed count; zero for a bad node or empty interval
   assign span  = CNT_W'(iv_hi) - CNT_W'(iv_lo) + 1'b1;
   assign count = (node_ok_ff && (iv_lo <= iv_hi)) ? span - sum_ff : '0;

   // Memories
   always_ff @(posedge clock) begin
      if (cmd.accept && req_op == OP_LOAD && req_node_ok) begin
         iv_mem[req_node[NODE_AW-1:0]] <= {last_clamp, first_clamp};
      end
      if (cmd.accept) begin
         iv_rd_ff <= iv_mem[req_node[NODE_AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (tw_en) begin
         tree_mem[tw_addr] <= tw_data;
      end
      if (tr_en) begin
         tree_rd_ff <= tree_mem[tr_addr];
      end
   end

   // Next values
   always_comb begin
      clr_in       = clr_ff;
      i_in         = i_ff;
      lvl0_in      = lvl0_ff;
      up_in        = up_ff;
      l_in         = l_ff;
      r_in         = r_ff;
      sum_in       = sum_ff;
      op_in        = op_ff;
      node_ok_in   = node_ok_ff;
      out_valid_in = out_valid_ff;
      out_cnt_in   = out_cnt_ff;
      pend_in      = (cmd.q_left & l_ff[0]) | (cmd.q_right & r_ff[0]);

      if (cmd.clr_en) begin
         clr_in = clr_ff + 1'b1;
      end
      if (cmd.accept) begin
         op_in      = req_op;
         node_ok_in = req_node_ok;
      end
      if (cmd.tog_init) begin
         i_in    = TREE_AW'(LEAVES) + TREE_AW'(iv_lo);
         lvl0_in = 1'b1;
      end
      if (cmd.tog_write) begin
         i_in    = i_ff >> 1;
         lvl0_in = 1'b0;
         up_in   = up_now;
      end
      if (cmd.q_init) begin
         l_in   = (TREE_AW + 1)'(LEAVES) + (TREE_AW + 1)'(iv_lo);
         r_in   = (TREE_AW + 1)'(LEAVES) + (TREE_AW + 1)'(iv_hi) + 1'b1;
         sum_in = '0;
      end else if (pend_ff) begin
         sum_in = sum_ff + tree_rd_ff;
      end
      if (cmd.q_left && l_ff[0]) begin
         l_in = l_ff + 1'b1;
      end
      if (cmd.q_right && r_ff[0]) begin
         r_in = r_dec;
      end
      if (cmd.q_shift) begin
         l_in = l_ff >> 1;
         r_in = r_ff >> 1;
      end
      if (cmd.out_load) begin
         out_valid_in = 1'b1;
         out_cnt_in   = count;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff       <= '0;
         pend_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         clr_ff       <= clr_in;
         pend_ff      <= pend_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      i_ff       <= i_in;
      lvl0_ff    <= lvl0_in;
      up_ff      <= up_in;
      l_ff       <= l_in;
      r_ff       <= r_in;
      sum_ff     <= sum_in;
      op_ff      <= op_in;
      node_ok_ff <= node_ok_in;
      out_cnt_ff <= out_cnt_in;
   end

   // Result channel
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = RSP_W'(out_cnt_ff);

   // Status
   assign sts.req_op   = req_op;
   assign sts.op       = op_ff;
   assign sts.node_ok  = node_ok_ff;
   assign sts.clr_last = (clr_ff == TREE_AW'(TREE_DEPTH - 1));
   assign sts.i_top    = (i_ff == TREE_AW'(1));
   assign sts.l_lt_r   = (l_ff < r_ff);
   assign sts.out_free = ~out_valid_ff | rsp_tready;

endmodule

FILE: sv/subtree_toggle_count_segment_tree.sv
// Subtree present-count engine over a removed-count segment tree.
// req channel: one beat per command. Op 0 loads a node's first and last
// position, op 1 toggles the flag at the node's first position, op 2
// asks for the number of present positions in the node's interval.
// rsp channel: one beat per op 2 command carrying present_count; other
// ops produce nothing.
// One command is worked at a time; req_tready is high only when idle.
// Load is complete on acceptance. Toggle fetches the node, then does one
// tree read and one write per level, log2(LEAVES) + 1 levels in all.
// Query fetches the node, walks the tree levels, each with a left bound,
// right bound and shift step, ends with a closing bound check and loads
// the result; the level walk uses the single tree read port.
// After reset all 2 * LEAVES tree entries are swept to zero, one entry a
// cycle; req_tready stays low during the sweep.
// The interval table is not cleared: query or toggle a node only after
// loading it.
// The result sits in an output register; if rsp_tready is low when the
// next query completes, the engine waits in place until it drains.
module subtree_toggle_count_segment_tree import stc_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [REQ_W-1:0] req_tdata,  // op, node, first_pos, last_pos
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [RSP_W-1:0] rsp_tdata   // present_count
);

   cmd_type cmd;
   sts_type sts;

   stc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .sts        (sts),
      .cmd        (cmd)
   );

   stc_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .cmd        (cmd),
      .sts        (sts)
   );

   assign req_tready = cmd.ready;

   // No beat accepted while the tree sweep runs
   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      !(cmd.ready && cmd.clr_en))
      else $error("request ready during tree clear");

   // A result is never loaded over one not yet taken
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> sts.out_free)
      else $error("result register overwritten");

   // Toggle and query occupy the engine after acceptance
   a_busy_after_walk: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready &&
       (sts.req_op == OP_TOGGLE || sts.req_op == OP_QUERY)) |=> !req_tready)
      else $error("engine ready right after a tree command");

endmodule
